@@ src/tqsa_pkg.sv @@
// Shared types and codes for the two-queue shared store block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tqsa_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;

	typedef logic [1:0]        op_t;
	typedef logic [1:0]        stat_t;
	typedef logic [DATA_W-1:0] word_t;

	localparam op_t OP_ENQ_ONE = 2'd0;
	localparam op_t OP_ENQ_TWO = 2'd1;
	localparam op_t OP_DEQ_ONE = 2'd2;
	localparam op_t OP_DEQ_TWO = 2'd3;

	localparam stat_t ST_DONE  = 2'd0;
	localparam stat_t ST_FULL  = 2'd1;
	localparam stat_t ST_EMPTY = 2'd2;

	localparam word_t WORD_NEG_ONE = '1;

	// controller -> datapath
	typedef struct packed {
		logic take;      // request accepted this cycle
		logic out_item;  // load result regs from the enqueue result
		logic out_read;  // load result regs from the store read
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_deq;    // incoming request is a dequeue
	} dp_sts_t;

endpackage

@@ src/two_queues_shared_array.sv @@
// Two queues sharing one word store: queue one grows up from entry 0, queue two
// grows down from the top entry.
//
// Input channel (in_valid / in_stall): operation and data_in form one request;
// it is taken at a clock edge with in_valid high and in_stall low. Operations
// are enqueue one, enqueue two, dequeue one, dequeue two.
// Output channel (out_valid / out_stall): one result per request with
// data_out, status (done, full, empty) and the queue and store flags after the
// request. A stalled result holds its value until taken.
//
// An enqueue result is valid the cycle after it is taken; a dequeue result
// passes through the registered read port of the word store, then the result regs.
// Throughput: one enqueue per cycle while no result is stalled; after a dequeue
// in_stall is high in the store read wait state. A new request is taken while
// the previous result is being taken on the output; while a result is stalled,
// in_stall stays high. Space is reclaimed only when a queue drains fully.
// Reset (arst_n low) empties both queues at once; no clearing pass is needed,
// entries are only read after they were written.
// Depends on tqsa_pkg, tqsa_ctrl and tqsa_dpath.
`timescale 1ns / 1ps

module two_queues_shared_array #(
	parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tqsa_pkg::op_t   operation,
	input  tqsa_pkg::word_t data_in,
	output logic            out_valid,
	input  logic            out_stall,
	output tqsa_pkg::word_t data_out,
	output tqsa_pkg::stat_t status,
	output logic            first_empty,
	output logic            second_empty,
	output logic            store_full
);
	import tqsa_pkg::*;

	cmd_t    cmd;
	dp_sts_t dp_sts;

	tqsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dp_sts   (dp_sts),
		.cmd      (cmd)
	);

	tqsa_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.dp_sts      (dp_sts),
		.operation   (operation),
		.data_in     (data_in),
		.data_out    (data_out),
		.status      (status),
		.first_empty (first_empty),
		.second_empty(second_empty),
		.store_full  (store_full)
	);

endmodule

@@ src/tqsa_ctrl.sv @@
// Controller for the two-queue shared store: request handshake, read wait state
// and result valid. Depends on tqsa_pkg.
`timescale 1ns / 1ps

module tqsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  tqsa_pkg::dp_sts_t dp_sts,
	output tqsa_pkg::cmd_t   cmd
);
	import tqsa_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic take;

	// the result slot is free when empty or draining this cycle
	assign in_stall = (state_q == S_READ) || (out_valid_q && out_stall);
	assign take     = in_valid && !in_stall;

	always_comb begin
		cmd.take     = take;
		cmd.out_item = take && !dp_sts.is_deq;
		cmd.out_read = (state_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take && dp_sts.is_deq)
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_item || cmd.out_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_IDLE)
		else $error("read wait state held longer than one cycle");

	a_deq_goes_read: assert property (@(posedge clk) disable iff (!arst_n)
		take && dp_sts.is_deq |=> cmd.out_read)
		else $error("dequeue did not load its result next cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_read |-> !out_valid_q)
		else $error("store read result overwrote a pending result");

endmodule

@@ src/tqsa_dpath.sv @@
// Datapath for the two-queue shared store: pointers, word store, result regs.
// Depends on tqsa_pkg; driven by tqsa_ctrl commands.
`timescale 1ns / 1ps

module tqsa_dpath #(
	parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tqsa_pkg::cmd_t    cmd,
	output tqsa_pkg::dp_sts_t dp_sts,
	input  tqsa_pkg::op_t     operation,
	input  tqsa_pkg::word_t   data_in,
	output tqsa_pkg::word_t   data_out,
	output tqsa_pkg::stat_t   status,
	output logic              first_empty,
	output logic              second_empty,
	output logic              store_full
);
	import tqsa_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] TOP     = CW'(DEPTH);
	localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);

	// t1_q = tail_one + 1, t2_q = tail_two; heads are plain indexes
	logic [CW-1:0] t1_q, t2_q;
	logic [AW-1:0] h1_q, h2_q;

	logic [CW-1:0] t1_d, t2_d, t2_dec;
	logic [AW-1:0] h1_d, h2_d;
	logic          e1, e2, full;
	stat_t         st_c;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;

	word_t mem [DEPTH];
	word_t rd_q;

	stat_t pend_st_q;
	logic  pend_e1_q, pend_e2_q, pend_full_q;

	word_t data_out_q;
	stat_t status_q;
	logic  e1_out_q, e2_out_q, full_out_q;

	assign e1     = (t1_q == '0);
	assign e2     = (t2_q == TOP);
	assign full   = (t1_q == t2_q);
	assign t2_dec = t2_q - CW'(1);

	assign dp_sts.is_deq = (operation == OP_DEQ_ONE) || (operation == OP_DEQ_TWO);

	always_comb begin
		t1_d  = t1_q;
		t2_d  = t2_q;
		h1_d  = h1_q;
		h2_d  = h2_q;
		st_c  = ST_DONE;
		we    = 1'b0;
		re    = 1'b0;
		waddr = t1_q[AW-1:0];
		raddr = h1_q;
		case (operation)
			OP_ENQ_ONE: begin
				if (full) begin
					st_c = ST_FULL;
				end else begin
					we   = 1'b1;
					t1_d = t1_q + CW'(1);
					if (e1)
						h1_d = '0;
				end
			end
			OP_ENQ_TWO: begin
				waddr = t2_dec[AW-1:0];
				if (full) begin
					st_c = ST_FULL;
				end else begin
					we   = 1'b1;
					t2_d = t2_dec;
					if (e2)
						h2_d = TOP_IDX;
				end
			end
			OP_DEQ_ONE: begin
				if (e1) begin
					st_c = ST_EMPTY;
				end else begin
					re = 1'b1;
					if (CW'(h1_q) == t1_q - CW'(1))
						t1_d = '0;
					else
						h1_d = h1_q + AW'(1);
				end
			end
			default: begin
				raddr = h2_q;
				if (e2) begin
					st_c = ST_EMPTY;
				end else begin
					re = 1'b1;
					if (CW'(h2_q) == t2_q)
						t2_d = TOP;
					else
						h2_d = h2_q - AW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0;
			t2_q <= TOP;
			h1_q <= '0;
			h2_q <= TOP_IDX;
		end else if (cmd.take) begin
			t1_q <= t1_d;
			t2_q <= t2_d;
			h1_q <= h1_d;
			h2_q <= h2_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && we)
			mem[waddr] <= data_in;
		if (cmd.take && re)
			rd_q <= mem[raddr];
	end

	// flags after the request, held for the read cycle of a dequeue
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_st_q   <= st_c;
			pend_e1_q   <= (t1_d == '0);
			pend_e2_q   <= (t2_d == TOP);
			pend_full_q <= (t1_d == t2_d);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_item) begin
			data_out_q <= '0;
			status_q   <= st_c;
			e1_out_q   <= (t1_d == '0);
			e2_out_q   <= (t2_d == TOP);
			full_out_q <= (t1_d == t2_d);
		end else if (cmd.out_read) begin
			data_out_q <= (pend_st_q == ST_EMPTY) ? WORD_NEG_ONE : rd_q;
			status_q   <= pend_st_q;
			e1_out_q   <= pend_e1_q;
			e2_out_q   <= pend_e2_q;
			full_out_q <= pend_full_q;
		end
	end

	assign data_out     = data_out_q;
	assign status       = status_q;
	assign first_empty  = e1_out_q;
	assign second_empty = e2_out_q;
	assign store_full   = full_out_q;

	a_tails_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		t1_q <= t2_q)
		else $error("queue tails crossed");

	a_head_one_in_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!e1 |-> CW'(h1_q) < t1_q)
		else $error("queue one head beyond its tail");

	a_head_two_in_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!e2 |-> CW'(h2_q) >= t2_q)
		else $error("queue two head beyond its tail");

endmodule

@@ dv/testbench.sv @@
// Testbench for two_queues_shared_array: random and directed queue operations,
// each result checked against an in-bench model of both queues and the store.
// Depends on tqsa_pkg and the two_queues_shared_array RTL.
`timescale 1ns / 1ps

module testbench;
	import tqsa_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int HOLD_LEN   = 100;
	localparam int CYCLE_MAX  = 500000;

	typedef struct {
		word_t data;
		stat_t stat;
		logic  q1_empty;
		logic  q2_empty;
		logic  full;
	} queue_result_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	op_t   operation = OP_ENQ_ONE;
	word_t data_in   = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t data_out;
	stat_t status;
	logic  first_empty;
	logic  second_empty;
	logic  store_full;

	// model of the block
	word_t store_mirror [DEPTH];
	int q1_head = -1;
	int q1_tail = -1;
	int q2_head = DEPTH;
	int q2_tail = DEPTH;

	queue_result_t pending_results[$];
	int errors    = 0;
	int cycles    = 0;
	int idle_pct  = 25;
	bit quiet     = 1'b0;
	bit hold_req  = 1'b0;
	int hold_left = 0;
	int burst_left = 0;
	bit burst_on  = 1'b0;

	two_queues_shared_array #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.status(status),
		.first_empty(first_empty),
		.second_empty(second_empty),
		.store_full(store_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit model_full();
		return q1_tail + 1 == q2_tail;
	endfunction

	function automatic queue_result_t predict_queue_op(op_t op, word_t val);
		queue_result_t r;
		r.data = '0;
		r.stat = ST_DONE;
		case (op)
			OP_ENQ_ONE: begin
				if (model_full()) begin
					r.stat = ST_FULL;
				end else begin
					if (q1_head == -1) q1_head = 0;
					q1_tail++;
					store_mirror[q1_tail] = val;
				end
			end
			OP_ENQ_TWO: begin
				if (model_full()) begin
					r.stat = ST_FULL;
				end else begin
					if (q2_head == DEPTH) q2_head = DEPTH - 1;
					q2_tail--;
					store_mirror[q2_tail] = val;
				end
			end
			OP_DEQ_ONE: begin
				if (q1_head == -1) begin
					r.data = WORD_NEG_ONE;
					r.stat = ST_EMPTY;
				end else begin
					r.data = store_mirror[q1_head];
					// draining the queue gives its slots back
					if (q1_head == q1_tail) begin
						q1_head = -1;
						q1_tail = -1;
					end else begin
						q1_head++;
					end
				end
			end
			default: begin
				if (q2_head == DEPTH) begin
					r.data = WORD_NEG_ONE;
					r.stat = ST_EMPTY;
				end else begin
					r.data = store_mirror[q2_head];
					if (q2_head == q2_tail) begin
						q2_head = DEPTH;
						q2_tail = DEPTH;
					end else begin
						q2_head--;
					end
				end
			end
		endcase
		r.q1_empty = (q1_head == -1);
		r.q2_empty = (q2_head == DEPTH);
		r.full     = model_full();
		return r;
	endfunction

	// offer one request, optionally after an idle burst, and wait until taken
	task automatic send_req(op_t op, word_t val);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data_in   <= val;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_queue_op(op, val));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_dequeue();
		send_req(OP_DEQ_ONE, $urandom());
		send_req(OP_DEQ_TWO, $urandom());
	endtask

	task automatic test_extremes();
		send_req(OP_ENQ_ONE, 32'h8000_0000);
		send_req(OP_ENQ_ONE, 32'h7fff_ffff);
		send_req(OP_ENQ_TWO, 32'h0000_0000);
		send_req(OP_ENQ_TWO, 32'hffff_ffff);
		send_req(OP_DEQ_ONE, 32'h5555_5555);
		send_req(OP_DEQ_TWO, 32'haaaa_aaaa);
	endtask

	// slots freed by partial dequeues stay used, so the store fills early
	task automatic test_store_full();
		bit side = 1'b0;
		while (!model_full()) begin
			send_req(side ? OP_ENQ_TWO : OP_ENQ_ONE, $urandom());
			side = ~side;
		end
		send_req(OP_ENQ_ONE, $urandom());
		send_req(OP_ENQ_TWO, $urandom());
	endtask

	// receiver holds off while dequeues wait on in_stall; both queues drain and reset
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (DEPTH + 4) begin
			send_req(OP_DEQ_ONE, $urandom());
			send_req(OP_DEQ_TWO, $urandom());
		end
		send_req(OP_ENQ_ONE, $urandom());
		send_req(OP_ENQ_TWO, $urandom());
	endtask

	task automatic test_sender_pause();
		repeat (5) begin
			send_req(OP_ENQ_ONE, $urandom());
			send_req(OP_ENQ_TWO, $urandom());
		end
		wait_drained();
		repeat (6) begin
			send_req(OP_DEQ_ONE, $urandom());
			send_req(OP_DEQ_TWO, $urandom());
		end
	endtask

	// phases lean toward filling, draining or a mix, so full and reclaim recur
	task automatic test_random(int count);
		int mode;
		int phase_left = 0;
		int enq_pct    = 50;
		int two_pct    = 50;
		bit enq;
		bit two;
		for (int i = 0; i < count; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				mode       = $urandom_range(0, 2);
				enq_pct    = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
				two_pct    = $urandom_range(0, 1) ? 50 : $urandom_range(10, 90);
				idle_pct   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
			end
			phase_left--;
			enq = $urandom_range(0, 99) < enq_pct;
			two = $urandom_range(0, 99) < two_pct;
			if (enq)
				send_req(two ? OP_ENQ_TWO : OP_ENQ_ONE, $urandom());
			else
				send_req(two ? OP_DEQ_TWO : OP_DEQ_ONE, $urandom());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dequeue();
		test_extremes();
		test_store_full();
		test_backpressure();
		test_sender_pause();
		test_random(1500);
		quiet = 1'b1;
		test_random(150);
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver stalls: a long hold on request, none when quiet, else random bursts
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= burst_on;
		end else begin
			burst_on   = ($urandom_range(0, 2) == 0);
			burst_left = $urandom_range(1, 16);
			out_stall <= burst_on;
		end
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending: data_out %h status %0d",
					$time, data_out, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (data_out !== want.data) begin
					$display("%0t: data_out expected %h got %h", $time, want.data, data_out);
					errors++;
				end
				if (status !== want.stat) begin
					$display("%0t: status expected %0d got %0d", $time, want.stat, status);
					errors++;
				end
				if (first_empty !== want.q1_empty) begin
					$display("%0t: first_empty expected %b got %b",
						$time, want.q1_empty, first_empty);
					errors++;
				end
				if (second_empty !== want.q2_empty) begin
					$display("%0t: second_empty expected %b got %b",
						$time, want.q2_empty, second_empty);
					errors++;
				end
				if (store_full !== want.full) begin
					$display("%0t: store_full expected %b got %b", $time, want.full, store_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
